[rtl/sik_pkg.sv]
// Shared types, constants and the CORDIC arc table for the SCARA inverse
// kinematics block. No dependencies.
package sik_pkg;

   localparam int CORDIC_W   = 34;  // CORDIC datapath width
   localparam int ANGLE_W    = 34;  // atan2 result width, binary angle units
   localparam int SCALE_BITS = 30;  // CORDIC operands are kept below 2^30
   localparam int DIV_STEPS  = 30;  // quotient bits of the elbow cosine
   localparam int SQRT_STEPS = 31;  // root bits of the elbow sine

   localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 34'sd2147483648;
   localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd1073741824;

   // Special-case flags of one atan2 operand pair, carried down a CORDIC lane
   typedef struct packed {
      logic y_zero;
      logic x_zero;
      logic x_neg;
      logic y_neg;
   } lane_flags_type;

   // atan(2^-i) in binary angle units, full turn = 2^32
   function automatic logic [31:0] arc_angle(input int unsigned idx);
      logic [31:0] r;
      case (idx)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         24: r = 32'h00000029;
         25: r = 32'h00000014;
         26: r = 32'h0000000A;
         27: r = 32'h00000005;
         28: r = 32'h00000003;
         29: r = 32'h00000001;
         30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

[rtl/sik_channel_if.sv]
// Valid/ready channels of the SCARA inverse kinematics block.
// Depends on nothing.
interface sik_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic signed [31:0] target_z;

   modport source (output valid, output target_x, output target_y, output target_z,
                   input ready);
   modport sink   (input valid, input target_x, input target_y, input target_z,
                   output ready);
endinterface

interface sik_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] shoulder_angle;
   logic signed [31:0] elbow_angle;
   logic signed [31:0] z_out;
   logic               unreachable;

   modport source (output valid, output shoulder_angle, output elbow_angle,
                   output z_out, output unreachable, input ready);
   modport sink   (input valid, input shoulder_angle, input elbow_angle,
                   input z_out, input unreachable, output ready);
endinterface

[rtl/sik_div_cell.sv]
// One restoring-division step of the elbow cosine quotient.
// Depends on nothing.
module sik_div_cell (
   input  logic        clock,
   input  logic        advance,
   input  logic [62:0] rem_in,
   input  logic [29:0] quot_in,
   input  logic [62:0] den_in,
   output logic [62:0] rem_out,
   output logic [29:0] quot_out,
   output logic [62:0] den_out
);

   logic [63:0] shifted;
   logic [63:0] diff;
   logic        take;

   always_comb begin
      shifted = {rem_in, 1'b0};
      diff    = shifted - {1'b0, den_in};
      take    = shifted >= {1'b0, den_in};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_out  <= take ? diff[62:0] : shifted[62:0];
         quot_out <= {quot_in[28:0], take};
         den_out  <= den_in;
      end
   end

endmodule

[rtl/sik_sqrt_cell.sv]
// One digit step of the integer square root of the elbow sine.
// Depends on sik_pkg.
module sik_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic        clock,
   input  logic        advance,
   input  logic [61:0] rad_in,
   input  logic [61:0] root_in,
   output logic [61:0] rad_out,
   output logic [61:0] root_out
);

   localparam logic [61:0] BIT_VAL = 62'd1 << (2 * (sik_pkg::SQRT_STEPS - 1 - STEP));

   logic [61:0] trial;
   logic        take;

   always_comb begin
      trial = root_in + BIT_VAL;
      take  = rad_in >= trial;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_out  <= take ? rad_in - trial : rad_in;
         root_out <= take ? (root_in >> 1) + BIT_VAL : root_in >> 1;
      end
   end

endmodule

[rtl/sik_cordic_cell.sv]
// One vectoring CORDIC rotation, rounding shifts toward minus infinity.
// Depends on sik_pkg.
module sik_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic signed [sik_pkg::CORDIC_W-1:0]   cx_in,
   input  logic signed [sik_pkg::CORDIC_W-1:0]   cy_in,
   input  logic signed [sik_pkg::CORDIC_W-1:0]   z_in,
   input  sik_pkg::lane_flags_type               flags_in,
   output logic signed [sik_pkg::CORDIC_W-1:0]   cx_out,
   output logic signed [sik_pkg::CORDIC_W-1:0]   cy_out,
   output logic signed [sik_pkg::CORDIC_W-1:0]   z_out,
   output sik_pkg::lane_flags_type               flags_out
);

   localparam int CW = sik_pkg::CORDIC_W;
   localparam logic signed [CW-1:0] ARC =
      $signed({{(CW-32){1'b0}}, sik_pkg::arc_angle(STEP)});

   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;

   always_comb begin
      dx = cy_in >>> STEP;
      dy = cx_in >>> STEP;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (cy_in > 0) begin
            cx_out <= cx_in + dx;
            cy_out <= cy_in - dy;
            z_out  <= z_in + ARC;
         end else begin
            cx_out <= cx_in - dx;
            cy_out <= cy_in + dy;
            z_out  <= z_in - ARC;
         end
         flags_out <= flags_in;
      end
   end

endmodule

[rtl/sik_cordic_lane.sv]
// atan2(y, x) lane: operand scaling, a row of CORDIC cells and quadrant fix-up.
// Depends on sik_pkg and sik_cordic_cell.
module sik_cordic_lane #(
   parameter int W      = 64,
   parameter int STAGES = 24
) (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic signed [W-1:0]                  y_in,
   input  logic signed [W-1:0]                  x_in,
   output logic signed [sik_pkg::ANGLE_W-1:0]   angle_out
);

   localparam int CW  = sik_pkg::CORDIC_W;
   localparam int SHW = $clog2(W + 1);
   localparam int SB  = sik_pkg::SCALE_BITS;

   logic [W-1:0]            ax_in;
   logic [W-1:0]            ay_in;
   logic [SHW-1:0]          bitlen;
   logic [SHW-1:0]          sh_in;
   sik_pkg::lane_flags_type flags_in;

   logic [W-1:0]            ax_ff;
   logic [W-1:0]            ay_ff;
   logic [SHW-1:0]          sh_ff;
   sik_pkg::lane_flags_type flags0_ff;

   logic [W-1:0]            ax_sh;
   logic [W-1:0]            ay_sh;

   logic signed [CW-1:0]    cx_c [0:STAGES];
   logic signed [CW-1:0]    cy_c [0:STAGES];
   logic signed [CW-1:0]    z_c  [0:STAGES];
   sik_pkg::lane_flags_type flags_c [0:STAGES];

   logic signed [CW-1:0]    z_fold;
   logic signed [CW-1:0]    angle_in;

   always_comb begin
      ax_in = x_in[W-1] ? -x_in : x_in;
      ay_in = y_in[W-1] ? -y_in : y_in;
      bitlen = '0;
      for (int i = 0; i < W; i++) begin
         if (ax_in[i] || ay_in[i]) begin
            bitlen = SHW'(i + 1);
         end
      end
      sh_in = (bitlen > SHW'(SB)) ? bitlen - SHW'(SB) : '0;
      flags_in.y_zero = (y_in == '0);
      flags_in.x_zero = (x_in == '0);
      flags_in.x_neg  = x_in[W-1];
      flags_in.y_neg  = y_in[W-1];
   end

   // scale both magnitudes together below 2^30
   always_ff @(posedge clock) begin
      if (advance) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         sh_ff     <= sh_in;
         flags0_ff <= flags_in;
      end
   end

   always_comb begin
      ax_sh = ax_ff >> sh_ff;
      ay_sh = ay_ff >> sh_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cx_c[0]    <= $signed({{(CW-SB){1'b0}}, ax_sh[SB-1:0]});
         cy_c[0]    <= $signed({{(CW-SB){1'b0}}, ay_sh[SB-1:0]});
         z_c[0]     <= '0;
         flags_c[0] <= flags0_ff;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      sik_cordic_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .advance   (advance),
         .cx_in     (cx_c[i]),
         .cy_in     (cy_c[i]),
         .z_in      (z_c[i]),
         .flags_in  (flags_c[i]),
         .cx_out    (cx_c[i+1]),
         .cy_out    (cy_c[i+1]),
         .z_out     (z_c[i+1]),
         .flags_out (flags_c[i+1])
      );
   end

   // map the first-quadrant angle back to the operands' quadrant
   always_comb begin
      z_fold = flags_c[STAGES].x_neg ? sik_pkg::HALF_TURN - z_c[STAGES] : z_c[STAGES];
      if (flags_c[STAGES].y_zero) begin
         angle_in = flags_c[STAGES].x_neg ? sik_pkg::HALF_TURN : '0;
      end else if (flags_c[STAGES].x_zero) begin
         angle_in = flags_c[STAGES].y_neg ? -sik_pkg::QUARTER_TURN : sik_pkg::QUARTER_TURN;
      end else begin
         angle_in = flags_c[STAGES].y_neg ? -z_fold : z_fold;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_out <= angle_in;
      end
   end

endmodule

[rtl/scara_inverse_kinematics.sv]
// Two-link SCARA inverse kinematics, top level.
// Depends on sik_pkg, sik_channel_if, sik_div_cell, sik_sqrt_cell, sik_cordic_lane.
//
// Takes one target transaction (x, y, z in Q16.16 mm) per clock and returns
// the shoulder and forearm angles in degrees with FRAC_BITS fraction bits, z
// copied, and a flag for targets out of reach (elbow cosine clamped to +-1,
// sine forced to zero). Every transaction travels from acceptance to the
// result register down the row of cells: a 30-cell restoring divider for
// the cosine, a 31-cell digit square root for the sine, and three parallel
// CORDIC lanes of CORDIC_STAGES cells each, plus multiply, scaling and
// conversion stages. The whole row advances together, so a new transaction
// enters every cycle; the row only holds while the result register is
// occupied, not taken, and the last stage carries a result. Link lengths
// are read live along the row; origin offsets and passthrough mode are
// sampled on entry, so write them only while no transaction is in flight. In
// passthrough mode x and y come back unchanged and the unreachable flag is 0.
// No clearing pass after reset.
module scara_inverse_kinematics #(
   parameter int CORDIC_STAGES = 24,
   parameter int FRAC_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   sik_req_if.sink     req,
   sik_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam logic [2:0] CSR_UPPER_ARM   = 3'd0;
   localparam logic [2:0] CSR_FOREARM     = 3'd1;
   localparam logic [2:0] CSR_OFFSET_X    = 3'd2;
   localparam logic [2:0] CSR_OFFSET_Y    = 3'd3;
   localparam logic [2:0] CSR_PASSTHROUGH = 3'd4;

   // stage numbers along the row
   localparam int S_IN   = 1;
   localparam int S_MUL  = S_IN + 1;
   localparam int S_NUM  = S_MUL + 1;
   localparam int S_DIV0 = S_NUM + 1;
   localparam int S_COS  = S_DIV0 + sik_pkg::DIV_STEPS + 1;
   localparam int S_CSQ  = S_COS + 1;
   localparam int S_SQ0  = S_CSQ + 1;
   localparam int S_KP   = S_SQ0 + sik_pkg::SQRT_STEPS + 1;
   localparam int S_KS   = S_KP + 1;
   localparam int S_LANE = S_KS + CORDIC_STAGES + 3;
   localparam int S_ANG  = S_LANE + 1;

   localparam int                 DEG_SHIFT = 29 - FRAC_BITS;
   localparam logic signed [43:0] DEG_RND   = 44'sd1 <<< (DEG_SHIFT - 1);
   localparam logic [30:0]        ONE_Q30   = 31'h40000000;
   localparam logic [61:0]        ONE_SQ    = 62'd1 << 60;

   typedef struct packed {
      logic [31:0]        x;
      logic [31:0]        y;
      logic [31:0]        z;
      logic               pass;
      logic signed [33:0] px;
      logic signed [33:0] py;
      logic               neg;
      logic               over;
      logic               eqf;
      logic               dnz;
      logic               unreach;
      logic signed [31:0] cosv;
   } side_type;

   // configuration registers
   logic [30:0]        upper_arm_ff;
   logic [30:0]        forearm_ff;
   logic signed [31:0] offset_x_ff;
   logic signed [31:0] offset_y_ff;
   logic               pass_ff;

   // row control
   logic               adv;
   logic               out_load;
   logic               vld_ff [1:S_ANG];
   side_type           side_ff [1:S_ANG];
   side_type           side_in;
   side_type           side_div;
   side_type           side_cos;

   // input shaping
   logic signed [33:0] px_in;
   logic signed [33:0] py_in;
   logic [32:0]        ux_in;
   logic [32:0]        uy_in;
   logic [1:0]         sh_in;
   logic [32:0]        ux_sh;
   logic [32:0]        uy_sh;

   logic [30:0]        a_ff, b_ff, c_ff, d_ff;
   logic [61:0]        aa_ff, bb_ff, cc_ff, dd_ff, cd_ff;
   logic [62:0]        sab, scd;
   logic signed [63:0] num;
   logic               num_neg_ff;
   logic [62:0]        unum_ff;
   logic [62:0]        den_ff;

   logic [62:0]        dv_rem_ff;
   logic [62:0]        dv_den_ff;
   logic [62:0]        rem_c  [0:sik_pkg::DIV_STEPS];
   logic [29:0]        quot_c [0:sik_pkg::DIV_STEPS];
   logic [62:0]        den_c  [0:sik_pkg::DIV_STEPS];

   logic [30:0]        q_full;
   logic signed [31:0] cos_in;
   logic signed [63:0] csq_full;
   logic [60:0]        csq_ff;
   logic [61:0]        sq_rad_ff;
   logic [61:0]        rad_c  [0:sik_pkg::SQRT_STEPS];
   logic [61:0]        root_c [0:sik_pkg::SQRT_STEPS];

   logic [30:0]        sin_kp;
   logic signed [63:0] pcos_full;
   logic signed [63:0] pcos_ff;
   logic [61:0]        psin_ff;
   logic [30:0]        sin_kp_ff;
   logic signed [63:0] k1_ff;
   logic signed [63:0] k2_ff;
   logic signed [31:0] sin_ks_ff;

   logic signed [sik_pkg::ANGLE_W-1:0] t_arm, t_tgt, t_elb;
   logic signed [35:0] theta_in;
   logic signed [35:0] theta_ff;
   logic signed [35:0] psi_ff;

   logic               rsp_valid_ff;
   logic [31:0]        shoulder_ff;
   logic [31:0]        elbow_ff;
   logic [31:0]        z_out_ff;
   logic               unreach_ff;

   // binary angle (full turn 2^32) to degrees, round half up, saturate
   function automatic logic [31:0] to_degrees(input logic signed [35:0] ang);
      logic signed [43:0] prod;
      logic signed [43:0] rnd;
      prod = $signed({{8{ang[35]}}, ang}) * 44'sd45;
      rnd  = (prod + DEG_RND) >>> DEG_SHIFT;
      if (rnd > 44'sd2147483647) begin
         return 32'h7FFFFFFF;
      end else if (rnd < -44'sd2147483648) begin
         return 32'h80000000;
      end else begin
         return rnd[31:0];
      end
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_arm_ff <= 31'd13107200;
         forearm_ff   <= 31'd13107200;
         offset_x_ff  <= '0;
         offset_y_ff  <= '0;
         pass_ff      <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_UPPER_ARM:   upper_arm_ff <= csr_write_data[30:0];
            CSR_FOREARM:     forearm_ff   <= csr_write_data[30:0];
            CSR_OFFSET_X:    offset_x_ff  <= $signed(csr_write_data);
            CSR_OFFSET_Y:    offset_y_ff  <= $signed(csr_write_data);
            CSR_PASSTHROUGH: pass_ff      <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // advance the row unless a result would be pushed into an occupied output
   assign out_load  = !rsp_valid_ff || rsp.ready;
   assign adv       = !vld_ff[S_ANG] || out_load;
   assign req.ready = adv;

   // move into the arm frame and pick a common scale for very distant targets
   always_comb begin
      px_in = -$signed({{2{req.target_x[31]}}, req.target_x})
              - $signed({{2{offset_x_ff[31]}}, offset_x_ff});
      py_in = $signed({{2{req.target_y[31]}}, req.target_y})
              + $signed({{2{offset_y_ff[31]}}, offset_y_ff});
      ux_in = px_in[33] ? 33'(-px_in) : px_in[32:0];
      uy_in = py_in[33] ? 33'(-py_in) : py_in[32:0];
      if (ux_in[32] || uy_in[32]) begin
         sh_in = 2'd2;
      end else if (ux_in[31] || uy_in[31]) begin
         sh_in = 2'd1;
      end else begin
         sh_in = 2'd0;
      end
      ux_sh = ux_in >> sh_in;
      uy_sh = uy_in >> sh_in;

      side_in         = '0;
      side_in.x       = req.target_x;
      side_in.y       = req.target_y;
      side_in.z       = req.target_z;
      side_in.pass    = pass_ff;
      side_in.px      = px_in;
      side_in.py      = py_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= S_ANG; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[S_IN] <= req.valid;
         for (int k = S_IN + 1; k <= S_ANG; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // pick up the divider flags and the clamped cosine on the way
   always_comb begin
      side_div         = side_ff[S_DIV0-1];
      side_div.neg     = num_neg_ff;
      side_div.over    = unum_ff > den_ff;
      side_div.eqf     = unum_ff == den_ff;
      side_div.dnz     = den_ff != '0;
      side_cos         = side_ff[S_COS-1];
      side_cos.cosv    = cos_in;
      side_cos.unreach = side_ff[S_COS-1].over;
   end

   // side data travels alongside the arithmetic
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[S_IN] <= side_in;
         for (int k = S_IN + 1; k <= S_ANG; k++) begin
            if (k == S_DIV0) begin
               side_ff[k] <= side_div;
            end else if (k == S_COS) begin
               side_ff[k] <= side_cos;
            end else begin
               side_ff[k] <= side_ff[k-1];
            end
         end
      end
   end

   // squares of the scaled coordinates and lengths, and the product of the lengths
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff  <= ux_sh[30:0];
         b_ff  <= uy_sh[30:0];
         c_ff  <= upper_arm_ff >> sh_in;
         d_ff  <= forearm_ff >> sh_in;
         aa_ff <= a_ff * a_ff;
         bb_ff <= b_ff * b_ff;
         cc_ff <= c_ff * c_ff;
         dd_ff <= d_ff * d_ff;
         cd_ff <= c_ff * d_ff;
      end
   end

   always_comb begin
      sab = {1'b0, aa_ff} + {1'b0, bb_ff};
      scd = {1'b0, cc_ff} + {1'b0, dd_ff};
      num = $signed({1'b0, sab}) - $signed({1'b0, scd});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_neg_ff <= num[63];
         unum_ff    <= num[63] ? 63'(-num) : num[62:0];
         den_ff     <= {cd_ff, 1'b0};
         dv_rem_ff  <= unum_ff;
         dv_den_ff  <= den_ff;
      end
   end

   // cosine quotient, one bit per cell
   assign rem_c[0]  = dv_rem_ff;
   assign quot_c[0] = '0;
   assign den_c[0]  = dv_den_ff;

   for (genvar i = 0; i < sik_pkg::DIV_STEPS; i++) begin : g_div
      sik_div_cell u_div (
         .clock    (clock),
         .advance  (adv),
         .rem_in   (rem_c[i]),
         .quot_in  (quot_c[i]),
         .den_in   (den_c[i]),
         .rem_out  (rem_c[i+1]),
         .quot_out (quot_c[i+1]),
         .den_out  (den_c[i+1])
      );
   end

   // clamp to one when out of reach, or when the quotient is exactly one
   always_comb begin
      if (side_ff[S_COS-1].over) begin
         q_full = ONE_Q30;
      end else if (side_ff[S_COS-1].eqf) begin
         q_full = side_ff[S_COS-1].dnz ? ONE_Q30 : '0;
      end else begin
         q_full = {1'b0, quot_c[sik_pkg::DIV_STEPS]};
      end
      cos_in   = side_ff[S_COS-1].neg ? -$signed({1'b0, q_full}) : $signed({1'b0, q_full});
      csq_full = side_ff[S_COS].cosv * side_ff[S_COS].cosv;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         csq_ff    <= csq_full[60:0];
         sq_rad_ff <= ONE_SQ - {1'b0, csq_ff};
      end
   end

   // sine as the root of 1 - cos^2, one digit per cell
   assign rad_c[0]  = sq_rad_ff;
   assign root_c[0] = '0;

   for (genvar j = 0; j < sik_pkg::SQRT_STEPS; j++) begin : g_sqrt
      sik_sqrt_cell #(.STEP(j)) u_sqrt (
         .clock    (clock),
         .advance  (adv),
         .rad_in   (rad_c[j]),
         .root_in  (root_c[j]),
         .rad_out  (rad_c[j+1]),
         .root_out (root_c[j+1])
      );
   end

   always_comb begin
      sin_kp    = side_ff[S_KP-1].unreach ? '0 : root_c[sik_pkg::SQRT_STEPS][30:0];
      pcos_full = $signed({1'b0, forearm_ff}) * side_ff[S_KP-1].cosv;
   end

   // k1 = L1 + L2*cos, k2 = L2*sin, both scaled by 2^30
   always_ff @(posedge clock) begin
      if (adv) begin
         pcos_ff   <= pcos_full;
         psin_ff   <= forearm_ff * sin_kp;
         sin_kp_ff <= sin_kp;
         k1_ff     <= $signed({3'b0, upper_arm_ff, 30'b0}) + pcos_ff;
         k2_ff     <= $signed({2'b0, psin_ff});
         sin_ks_ff <= $signed({1'b0, sin_kp_ff});
      end
   end

   // three atan2 lanes in parallel
   sik_cordic_lane #(.W(64), .STAGES(CORDIC_STAGES)) u_lane_arm (
      .clock     (clock),
      .advance   (adv),
      .y_in      (k1_ff),
      .x_in      (k2_ff),
      .angle_out (t_arm)
   );

   sik_cordic_lane #(.W(34), .STAGES(CORDIC_STAGES)) u_lane_tgt (
      .clock     (clock),
      .advance   (adv),
      .y_in      (side_ff[S_KS].px),
      .x_in      (side_ff[S_KS].py),
      .angle_out (t_tgt)
   );

   sik_cordic_lane #(.W(32), .STAGES(CORDIC_STAGES)) u_lane_elb (
      .clock     (clock),
      .advance   (adv),
      .y_in      (sin_ks_ff),
      .x_in      (side_ff[S_KS].cosv),
      .angle_out (t_elb)
   );

   assign theta_in = $signed({{2{t_arm[33]}}, t_arm}) - $signed({{2{t_tgt[33]}}, t_tgt});

   always_ff @(posedge clock) begin
      if (adv) begin
         theta_ff <= theta_in;
         psi_ff   <= $signed({{2{t_elb[33]}}, t_elb}) + theta_in;
      end
   end

   // result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= vld_ff[S_ANG];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && vld_ff[S_ANG]) begin
         z_out_ff <= side_ff[S_ANG].z;
         if (side_ff[S_ANG].pass) begin
            shoulder_ff <= side_ff[S_ANG].x;
            elbow_ff    <= side_ff[S_ANG].y;
            unreach_ff  <= 1'b0;
         end else begin
            shoulder_ff <= to_degrees(theta_ff);
            elbow_ff    <= to_degrees(psi_ff);
            unreach_ff  <= side_ff[S_ANG].unreach;
         end
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.shoulder_angle = $signed(shoulder_ff);
   assign rsp.elbow_angle    = $signed(elbow_ff);
   assign rsp.z_out          = $signed(z_out_ff);
   assign rsp.unreachable    = unreach_ff;

   // a stalled output with a result waiting behind it must not drop that result
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready && vld_ff[S_ANG] |=> vld_ff[S_ANG])
      else $error("last stage lost a transaction while the output was stalled");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result valid straight after reset");

   // the clamped cosine never leaves [-1, 1] in Q1.30
   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_COS] |-> (side_ff[S_COS].cosv <= 32'sd1073741824)
                     && (side_ff[S_COS].cosv >= -32'sd1073741824))
      else $error("elbow cosine outside unit range");

endmodule
